// ===== sv/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // action codes on in_tuser
  localparam logic [1:0] ACT_PUT        = 2'd0;
  localparam logic [1:0] ACT_CLEAR      = 2'd1;
  localparam logic [1:0] ACT_SET_CURSOR = 2'd2;
  localparam logic [1:0] ACT_READ       = 2'd3;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  localparam logic REG_TEXT_ATTR = 1'b0;

  // command fields wide enough for the largest screen geometry
  localparam int CMD_COL_W = 8;
  localparam int CMD_ROW_W = 6;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_CLEAR,
    CMD_SET_CURSOR,
    CMD_READ
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [7:0]           ch;
    logic [CMD_COL_W-1:0] col;
    logic [CMD_ROW_W-1:0] row;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR
  } state_t;

endpackage

// ===== sv/text_console_writer.sv =====
// Put, backspace, newline and set cursor pass the front register, queue and
// result register; read cell also passes the store read register. One item
// per cycle while results are taken, but the back takes no command during a
// read, a scroll (newline on the last row or put on a full last row) or a clear.
// Reset clears the cursor, queue and result register, and sets the attribute
// to 0x0F; the screen store is not cleared.
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode terminal: decode front, command queue, screen execution back.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // char_code[7:0], col[14:8], row[19:15], zero pad
  input  logic [1:0]  in_tuser,    // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // cursor_col[6:0], cursor_row[11:7],
                                   // cursor_position[22:12], cell_char[30:23],
                                   // cell_attr[38:31], zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]    text_attr_r, text_attr_nxt;
  logic          cfg_wr;
  logic          f_valid, f_ready;
  tcw_pkg::cmd_t f_cmd;
  logic          q_valid, q_pop;
  tcw_pkg::cmd_t q_cmd;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == tcw_pkg::REG_TEXT_ATTR) ? {24'd0, text_attr_r} : 32'd0;

  always_comb begin
    text_attr_nxt = text_attr_r;
    if (cfg_wr && cfg_paddr[2] == tcw_pkg::REG_TEXT_ATTR) begin
      text_attr_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= tcw_pkg::ATTR_RESET;
    end else begin
      text_attr_r <= text_attr_nxt;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  tcw_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .attr       (text_attr_r),
    .cmd_valid  (q_valid),
    .pop        (q_pop),
    .cmd        (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sv/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input transfers, decodes them into commands and clamps coordinates.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [23:0]   in_tdata,   // char_code[7:0], col[14:8], row[19:15], zero pad
  input  logic [1:0]    in_tuser,   // action[1:0]
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output tcw_pkg::cmd_t cmd
);

  logic          hold_v_r, hold_v_nxt;
  tcw_pkg::cmd_t cmd_r, cmd_nxt;
  logic          accept;
  logic [7:0]    in_ch;
  logic [6:0]    in_col;
  logic [4:0]    in_row;
  logic [tcw_pkg::CMD_COL_W-1:0] col_set, col_read;
  logic [tcw_pkg::CMD_ROW_W-1:0] row_sat;

  assign in_ch  = in_tdata[7:0];
  assign in_col = in_tdata[14:8];
  assign in_row = in_tdata[19:15];

  assign in_tready = !hold_v_r || cmd_ready;
  assign accept    = in_tvalid && in_tready;
  assign cmd_valid = hold_v_r;
  assign cmd       = cmd_r;

  always_comb begin
    col_set  = (32'(in_col) > COLUMNS) ? tcw_pkg::CMD_COL_W'(COLUMNS)
                                       : tcw_pkg::CMD_COL_W'(in_col);
    col_read = (32'(in_col) > COLUMNS - 1) ? tcw_pkg::CMD_COL_W'(COLUMNS - 1)
                                           : tcw_pkg::CMD_COL_W'(in_col);
    row_sat  = (32'(in_row) > ROWS - 1) ? tcw_pkg::CMD_ROW_W'(ROWS - 1)
                                        : tcw_pkg::CMD_ROW_W'(in_row);
  end

  always_comb begin
    hold_v_nxt = hold_v_r;
    cmd_nxt    = cmd_r;
    if (accept) begin
      hold_v_nxt  = 1'b1;
      cmd_nxt.ch  = in_ch;
      cmd_nxt.row = row_sat;
      cmd_nxt.col = col_set;
      case (in_tuser)
        tcw_pkg::ACT_PUT: begin
          if (in_ch == tcw_pkg::CH_NEWLINE) begin
            cmd_nxt.kind = tcw_pkg::CMD_NEWLINE;
          end else if (in_ch == tcw_pkg::CH_BACKSPACE) begin
            cmd_nxt.kind = tcw_pkg::CMD_BACKSPACE;
          end else begin
            cmd_nxt.kind = tcw_pkg::CMD_PUT;
          end
        end
        tcw_pkg::ACT_CLEAR:      cmd_nxt.kind = tcw_pkg::CMD_CLEAR;
        tcw_pkg::ACT_SET_CURSOR: cmd_nxt.kind = tcw_pkg::CMD_SET_CURSOR;
        tcw_pkg::ACT_READ: begin
          cmd_nxt.kind = tcw_pkg::CMD_READ;
          cmd_nxt.col  = col_read;
        end
        default: cmd_nxt.kind = tcw_pkg::CMD_PUT;
      endcase
    end else if (cmd_ready) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

// ===== sv/tcw_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// tcw_cmd_queue
// Two-entry command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module tcw_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output tcw_pkg::cmd_t pop_cmd
);

  tcw_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands against the screen store, keeps the cursor, drives results.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    attr,
  input  logic          cmd_valid,
  output logic          pop,
  input  tcw_pkg::cmd_t cmd,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [39:0]   out_tdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam logic [CW-1:0]   COL_FULL      = CW'(COLUMNS);
  localparam logic [CW-1:0]   COL_LAST      = CW'(COLUMNS - 1);
  localparam logic [RW-1:0]   ROW_LAST      = RW'(ROWS - 1);
  localparam logic [AW-1:0]   LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [CNTW-1:0] CNT_CELLS     = CNTW'(CELLS);
  localparam logic [CNTW-1:0] CNT_COLS      = CNTW'(COLUMNS);

  tcw_pkg::state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            pend_r, pend_nxt;
  logic [7:0]      ch_r, ch_nxt;
  logic [CW-1:0]   cur_col_r, cur_col_nxt;
  logic [RW-1:0]   cur_row_r, cur_row_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [39:0]     out_data_r, out_data_nxt;
  logic            pipe_v_r, pipe_v_nxt;
  logic [AW-1:0]   pipe_addr_r, pipe_addr_nxt;

  logic [15:0]     mem [CELLS];
  logic [15:0]     rd_data_r;
  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [15:0]     wdata;

  logic            out_free, emit;
  logic [7:0]      emit_char, emit_attr;
  logic [CW-1:0]   bs_col;
  logic [RW-1:0]   bs_row;
  logic [CW-1:0]   cmd_col;
  logic [RW-1:0]   cmd_row;
  logic [10:0]     pos;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cmd_col    = cmd.col[CW-1:0];
  assign cmd_row    = cmd.row[RW-1:0];

  // backspace target
  always_comb begin
    bs_col = cur_col_r;
    bs_row = cur_row_r;
    if (cur_col_r != '0) begin
      bs_col = cur_col_r - 1'b1;
    end else if (cur_row_r != '0) begin
      bs_col = COL_LAST;
      bs_row = cur_row_r - 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    ch_nxt        = ch_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    pipe_v_nxt    = 1'b0;
    pipe_addr_nxt = pipe_addr_r;
    pop           = 1'b0;
    emit          = 1'b0;
    emit_char     = 8'd0;
    emit_attr     = 8'd0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = {attr, tcw_pkg::CH_SPACE};
    re            = 1'b0;
    raddr         = '0;

    case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (cmd_valid && out_free) begin
          pop = 1'b1;
          case (cmd.kind)
            tcw_pkg::CMD_SET_CURSOR: begin
              cur_col_nxt = cmd_col;
              cur_row_nxt = cmd_row;
              emit        = 1'b1;
            end
            tcw_pkg::CMD_READ: begin
              re        = 1'b1;
              raddr     = AW'(cmd_row * COLUMNS + cmd_col);
              state_nxt = tcw_pkg::ST_READ;
            end
            tcw_pkg::CMD_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = tcw_pkg::ST_CLEAR;
            end
            tcw_pkg::CMD_BACKSPACE: begin
              we          = 1'b1;
              waddr       = AW'(bs_row * COLUMNS + bs_col);
              cur_col_nxt = bs_col;
              cur_row_nxt = bs_row;
              emit        = 1'b1;
            end
            tcw_pkg::CMD_NEWLINE: begin
              if (cur_row_r < ROW_LAST) begin
                cur_col_nxt = '0;
                cur_row_nxt = cur_row_r + 1'b1;
                emit        = 1'b1;
              end else begin
                pend_nxt  = 1'b0;
                cnt_nxt   = CNT_COLS;
                state_nxt = tcw_pkg::ST_SCROLL;
              end
            end
            tcw_pkg::CMD_PUT: begin
              wdata = {attr, cmd.ch};
              if (cur_col_r < COL_FULL) begin
                we          = 1'b1;
                waddr       = AW'(cur_row_r * COLUMNS + cur_col_r);
                cur_col_nxt = cur_col_r + 1'b1;
                emit        = 1'b1;
              end else if (cur_row_r < ROW_LAST) begin
                // full row: wrap to the next line, then write
                we          = 1'b1;
                waddr       = AW'((cur_row_r + 1'b1) * COLUMNS);
                cur_col_nxt = CW'(1);
                cur_row_nxt = cur_row_r + 1'b1;
                emit        = 1'b1;
              end else begin
                // full last row: scroll, char lands in column 0 during fill
                pend_nxt  = 1'b1;
                ch_nxt    = cmd.ch;
                cnt_nxt   = CNT_COLS;
                state_nxt = tcw_pkg::ST_SCROLL;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      tcw_pkg::ST_READ: begin
        emit      = 1'b1;
        emit_char = rd_data_r[7:0];
        emit_attr = rd_data_r[15:8];
        state_nxt = tcw_pkg::ST_IDLE;
      end

      tcw_pkg::ST_SCROLL: begin
        // read cell n, write it to n - COLUMNS in the following cycle
        if (pipe_v_r) begin
          we    = 1'b1;
          waddr = pipe_addr_r;
          wdata = rd_data_r;
        end
        if (cnt_r < CNT_CELLS) begin
          re            = 1'b1;
          raddr         = cnt_r[AW-1:0];
          pipe_v_nxt    = 1'b1;
          pipe_addr_nxt = AW'(cnt_r - CNT_COLS);
          cnt_nxt       = cnt_r + 1'b1;
        end else begin
          cnt_nxt   = '0;
          state_nxt = tcw_pkg::ST_FILL;
        end
      end

      tcw_pkg::ST_FILL: begin
        we    = 1'b1;
        waddr = LAST_ROW_BASE + cnt_r[AW-1:0];
        if (pend_r && cnt_r == '0) begin
          wdata = {attr, ch_r};
        end
        if (cnt_r == CNTW'(COLUMNS - 1)) begin
          cur_col_nxt = pend_r ? CW'(1) : '0;
          cur_row_nxt = ROW_LAST;
          emit        = 1'b1;
          state_nxt   = tcw_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      tcw_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_r[AW-1:0];
        if (cnt_r == CNTW'(CELLS - 1)) begin
          cur_col_nxt = '0;
          cur_row_nxt = '0;
          emit        = 1'b1;
          state_nxt   = tcw_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    pos           = 11'(cur_row_nxt * COLUMNS + cur_col_nxt);
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, emit_attr, emit_char, pos, 5'(cur_row_nxt), 7'(cur_col_nxt)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_IDLE;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      out_valid_r <= 1'b0;
      pipe_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      out_valid_r <= out_valid_nxt;
      pipe_v_r    <= pipe_v_nxt;
    end
    cnt_r       <= cnt_nxt;
    pend_r      <= pend_nxt;
    ch_r        <= ch_nxt;
    pipe_addr_r <= pipe_addr_nxt;
    out_data_r  <= out_data_nxt;
  end

  // screen store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

`ifndef SYNTH
  a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tcw_pkg::ST_IDLE) |-> !pop)
    else $error("command taken while a multi-cycle command is running");

  a_busy_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tcw_pkg::ST_IDLE) |-> !out_valid_r)
    else $error("result register occupied during a multi-cycle command");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(pop) || $past(state_r != tcw_pkg::ST_IDLE)))
    else $error("result appeared without a command behind it");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r <= COL_FULL) && (cur_row_r <= ROW_LAST))
    else $error("cursor left the screen");
`endif

endmodule
